@@ design/optimal_bst_cost_table_macros.svh @@
// ----------------------------------------------------------------------------
// Optimal BST cost table: assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef OPTIMAL_BST_COST_TABLE_MACROS_SVH
`define OPTIMAL_BST_COST_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define OBST_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("optimal_bst_cost_table: assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define OBST_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("optimal_bst_cost_table: assertion failed");

`endif

@@ design/obst_pkg.sv @@
// ----------------------------------------------------------------------------
// Optimal BST cost table package
// Field widths, sequencer step map, jump conditions and the control store.
// ----------------------------------------------------------------------------
package obst_pkg;

  localparam int unsigned KEY_W    = 4;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned SUM_W    = 21;
  localparam int unsigned COST_W   = 32;

  typedef logic [KEY_W-1:0]    key_idx_t;
  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef logic [SUM_W-1:0]    wsum_t;
  typedef logic [COST_W-1:0]   cost_t;

  // Control store addresses. The last step falls through to the first.
  typedef enum logic [2:0] {
    STEP_IDLE   = 3'd0,
    STEP_SEED   = 3'd1,
    STEP_FIRST  = 3'd2,
    STEP_WRD    = 3'd3,
    STEP_WLD    = 3'd4,
    STEP_EVAL   = 3'd5,
    STEP_EMIT   = 3'd6,
    STEP_BRANCH = 3'd7
  } step_e;

  // Jump to the target when the condition holds, else step on.
  typedef enum logic [2:0] {
    COND_NEXT,
    COND_WAIT_START,
    COND_SEED_MORE,
    COND_K_MORE,
    COND_OUT_BUSY,
    COND_RUN_MORE
  } cond_e;

  typedef struct packed {
    logic  seed;   // write gap weight into the diagonal of both tables
    logic  first;  // start with the single-key intervals
    logic  ws_rd;  // read weight sum of the interval minus its top key
    logic  w_ld;   // form weight sum, open the root search
    logic  eval;   // try one root, fetch the next
    logic  emit;   // store cost, present result, advance the interval
    cond_e cond;
    step_e target;
  } ucode_t;

  function automatic ucode_t ucode_rom(step_e step);
    ucode_t uw;
    uw = '{seed: 1'b0, first: 1'b0, ws_rd: 1'b0, w_ld: 1'b0, eval: 1'b0,
           emit: 1'b0, cond: COND_NEXT, target: STEP_IDLE};
    case (step)
      STEP_IDLE: begin
        uw.cond   = COND_WAIT_START;
        uw.target = STEP_IDLE;
      end
      STEP_SEED: begin
        uw.seed   = 1'b1;
        uw.cond   = COND_SEED_MORE;
        uw.target = STEP_SEED;
      end
      STEP_FIRST: begin
        uw.first = 1'b1;
      end
      STEP_WRD: begin
        uw.ws_rd = 1'b1;
      end
      STEP_WLD: begin
        uw.w_ld = 1'b1;
      end
      STEP_EVAL: begin
        uw.eval   = 1'b1;
        uw.cond   = COND_K_MORE;
        uw.target = STEP_EVAL;
      end
      STEP_EMIT: begin
        uw.emit   = 1'b1;
        uw.cond   = COND_OUT_BUSY;
        uw.target = STEP_EMIT;
      end
      STEP_BRANCH: begin
        uw.cond   = COND_RUN_MORE;
        uw.target = STEP_WRD;
      end
      default: begin
        uw.cond   = COND_NEXT;
      end
    endcase
    return uw;
  endfunction

endpackage

@@ design/optimal_bst_cost_table.sv @@
// ----------------------------------------------------------------------------
// Optimal binary search tree cost table
// Load items write one slot each (key and gap weight, unsigned Q0.16); the
// item whose slot equals key_count also starts the dynamic programme over
// keys 1..n. Every interval [i,j] gives one result item (bounds, best root,
// expected cost), by growing length, then growing i; last_result marks [1,n].
// Both channels use valid/stall. Loads are accepted one per cycle while idle;
// in_stall_o stays high for the whole run. The EVAL step tries one root per
// cycle through the two read ports of the cost memory. A stall on the output
// holds the EMIT step; the output register lets the last result wait while
// new loads are taken. key_count is written through cfg_we_i/cfg_wdata_i;
// the user must write it only while idle; the block does not enforce it. Reset
// sets it to 5, returns the sequencer to idle and drops any pending result.
// Weight and table memories are not cleared by reset.
// ----------------------------------------------------------------------------
`include "optimal_bst_cost_table_macros.svh"

module optimal_bst_cost_table #(
  parameter int unsigned MAX_KEYS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration: key_count
  input  logic              cfg_we_i,
  input  obst_pkg::key_idx_t cfg_wdata_i,
  // load channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  obst_pkg::key_idx_t slot_index_i,
  input  obst_pkg::weight_t key_weight_i,
  input  obst_pkg::weight_t gap_weight_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output obst_pkg::key_idx_t first_key_o,
  output obst_pkg::key_idx_t final_key_o,
  output obst_pkg::key_idx_t best_root_o,
  output obst_pkg::cost_t   expected_cost_o,
  output logic              last_result_o
);
  import obst_pkg::*;

  localparam int unsigned SIDE  = MAX_KEYS + 1;
  localparam int unsigned DEPTH = SIDE * SIDE;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned KIW   = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int unsigned GIW   = $clog2(SIDE);
  localparam key_idx_t    MAX_KEYS_L = KEY_W'(MAX_KEYS);
  localparam key_idx_t    ONE        = KEY_W'(1);

  // Table entry (r,c), row r from 1, column c from 0.
  function automatic logic [AW-1:0] tix(key_idx_t r, key_idx_t c);
    return AW'((r - ONE) * SIDE + c);
  endfunction

  // ---------------- sequencer ----------------
  step_e    upc_q;
  ucode_t   uw;
  logic     jump;
  logic     accept, start, emit_fire;

  // ---------------- registers ----------------
  key_idx_t key_count_q;
  key_idx_t n_q, i_q, j_q, k_q, len_q, broot_q;
  wsum_t    w_q, ws_rd_q;
  cost_t    best_q, rd_a_q, rd_b_q;

  weight_t  key_w_q [MAX_KEYS];
  weight_t  gap_w_q [SIDE];
  wsum_t    ws_mem  [DEPTH];
  cost_t    cost_mem[DEPTH];

  logic     out_valid_q, last_q;
  key_idx_t first_q, final_q, root_q;
  cost_t    cost_out_q;

  // ---------------- datapath signals ----------------
  key_idx_t        k_rd;
  logic [AW-1:0]   rd_a_addr, rd_b_addr, wr_addr;
  wsum_t           w_d;
  logic [COST_W+1:0] trial_full;
  cost_t           trial;
  weight_t         seed_gap;

  assign uw        = ucode_rom(upc_q);
  assign in_stall_o = (upc_q != STEP_IDLE);
  assign accept    = in_valid_i && !in_stall_o;
  assign start     = accept && (slot_index_i == key_count_q) &&
                     (key_count_q >= ONE) && (key_count_q <= MAX_KEYS_L);
  assign emit_fire = uw.emit && !(out_valid_q && out_stall_i);

  always_comb begin
    case (uw.cond)
      COND_NEXT:       jump = 1'b0;
      COND_WAIT_START: jump = !start;
      COND_SEED_MORE:  jump = (i_q != n_q + ONE);
      COND_K_MORE:     jump = (k_q != j_q);
      COND_OUT_BUSY:   jump = out_valid_q && out_stall_i;
      COND_RUN_MORE:   jump = (len_q <= n_q);
      default:         jump = 1'b0;
    endcase
  end

  // The step counter wraps from the branch step back to idle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= STEP_IDLE;
    end else if (jump) begin
      upc_q <= uw.target;
    end else begin
      upc_q <= step_e'(upc_q + 3'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= KEY_W'(5);
    end else if (cfg_we_i) begin
      key_count_q <= cfg_wdata_i;
    end
  end

  // Load slots; slots beyond the table are dropped.
  always_ff @(posedge clk_i) begin
    if (accept && (slot_index_i <= MAX_KEYS_L)) begin
      if (slot_index_i >= ONE) begin
        key_w_q[KIW'(slot_index_i - ONE)] <= key_weight_i;
      end
      gap_w_q[GIW'(slot_index_i)] <= gap_weight_i;
    end
  end

  // ---------------- addresses and arithmetic ----------------
  assign k_rd      = uw.w_ld ? i_q : k_q + ONE;
  assign rd_a_addr = tix(i_q, k_rd - ONE);
  assign rd_b_addr = tix(k_rd + ONE, j_q);
  assign wr_addr   = uw.seed ? tix(i_q, i_q - ONE) : tix(i_q, j_q);
  assign seed_gap  = gap_w_q[GIW'(i_q - ONE)];
  assign w_d       = ws_rd_q + SUM_W'(key_w_q[KIW'(j_q - ONE)]) +
                     SUM_W'(gap_w_q[GIW'(j_q)]);
  assign trial_full = {2'b00, rd_a_q} + {2'b00, rd_b_q} + (COST_W + 2)'(w_q);
  assign trial     = (|trial_full[COST_W+1:COST_W]) ? '1 : trial_full[COST_W-1:0];

  // Weight sum memory: one write, one registered read.
  always_ff @(posedge clk_i) begin
    if (uw.seed) begin
      ws_mem[wr_addr] <= SUM_W'(seed_gap);
    end else if (uw.w_ld) begin
      ws_mem[wr_addr] <= w_d;
    end
    if (uw.ws_rd) begin
      ws_rd_q <= ws_mem[tix(i_q, j_q - ONE)];
    end
  end

  // Cost memory: one write, two registered reads for the two subtrees.
  always_ff @(posedge clk_i) begin
    if (uw.seed) begin
      cost_mem[wr_addr] <= COST_W'(seed_gap);
    end else if (emit_fire) begin
      cost_mem[wr_addr] <= best_q;
    end
    if (uw.w_ld || uw.eval) begin
      rd_a_q <= cost_mem[rd_a_addr];
      rd_b_q <= cost_mem[rd_b_addr];
    end
  end

  // Interval indices, root search.
  always_ff @(posedge clk_i) begin
    if (start) begin
      n_q <= key_count_q;
      i_q <= ONE;
    end
    if (uw.seed) begin
      i_q <= i_q + ONE;
    end
    if (uw.first) begin
      len_q <= ONE;
      i_q   <= ONE;
      j_q   <= ONE;
    end
    if (uw.w_ld) begin
      w_q     <= w_d;
      k_q     <= i_q;
      best_q  <= '1;
      broot_q <= i_q;
    end
    if (uw.eval) begin
      // strict compare keeps the lowest root on ties
      if (trial < best_q) begin
        best_q  <= trial;
        broot_q <= k_q;
      end
      k_q <= k_q + ONE;
    end
    if (emit_fire) begin
      if (j_q == n_q) begin
        len_q <= len_q + ONE;
        i_q   <= ONE;
        j_q   <= len_q + ONE;
      end else begin
        i_q <= i_q + ONE;
        j_q <= j_q + ONE;
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      first_q    <= i_q;
      final_q    <= j_q;
      root_q     <= broot_q;
      cost_out_q <= best_q;
      last_q     <= (i_q == ONE) && (j_q == n_q);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign first_key_o     = first_q;
  assign final_key_o     = final_q;
  assign best_root_o     = root_q;
  assign expected_cost_o = cost_out_q;
  assign last_result_o   = last_q;

  // ---------------- assertions ----------------
  `OBST_ASSERT_IMP(a_root_in_range, (upc_q == STEP_EVAL), (k_q >= i_q && k_q <= j_q))
  `OBST_ASSERT_IMP(a_emit_root_ok, emit_fire, (broot_q >= i_q && broot_q <= j_q))
  `OBST_ASSERT_NXT(a_last_to_idle, (emit_fire && i_q == ONE && j_q == n_q), ##1 (upc_q == STEP_IDLE))

endmodule
